// ===== src/mmcs_pkg.sv =====
package mmcs_pkg;

    // Frame buffer capacity and sample width
    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 16;

    // Fixed field widths
    localparam int DATA_W  = 16;
    localparam int ADDR_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = ADDR_W + 1;

    // Divider geometry: numerator 2*d*mv + range, denominator 2*range
    localparam int DEN_W   = DATA_W + 1;
    localparam int NUM_W   = 2 * DATA_W + 2;
    localparam int QUO_W   = DATA_W;
    localparam int STEP_W  = $clog2(QUO_W);

    localparam logic [DATA_W-1:0] SAMPLE_MASK =
        DATA_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [DATA_W-1:0] MAX_VALUE_RST = DATA_W'(255);
    localparam logic [CNT_W-1:0]  CAPACITY      = CNT_W'(MAX_SAMPLES);

    typedef logic [DATA_W-1:0] sample_t;

    // Item kinds carried on s_tuser
    typedef enum logic
    {
        MODE_LOAD  = 1'b0,
        MODE_DRAIN = 1'b1
    } mode_t;

    // Control between sequencer and divider
    typedef struct packed
    {
        logic start;
    } div_ctrl_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== src/mmcs_frame_store.sv =====
module mmcs_frame_store
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [mmcs_pkg::ADDR_W-1:0]   waddr,
    input  mmcs_pkg::sample_t             wdata,
    input  logic                          re,
    input  logic [mmcs_pkg::ADDR_W-1:0]   raddr,
    output mmcs_pkg::sample_t             rdata
);

    mmcs_pkg::sample_t mem [mmcs_pkg::MAX_SAMPLES];
    mmcs_pkg::sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mmcs_divider.sv =====
module mmcs_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mmcs_pkg::div_ctrl_t           ctrl,
    input  logic [mmcs_pkg::NUM_W-1:0]    numer,
    input  logic [mmcs_pkg::DEN_W-1:0]    denom,
    output mmcs_pkg::div_stat_t           stat,
    output logic [mmcs_pkg::QUO_W-1:0]    quotient
);

    // Restoring radix-2, one quotient bit per cycle.
    // Caller guarantees quotient < 2**QUO_W, so numer >> QUO_W < denom
    // and the partial remainder fits DEN_W bits.

    logic [mmcs_pkg::DEN_W-1:0]  rem_reg,  rem_next;
    logic [mmcs_pkg::QUO_W-1:0]  quo_reg,  quo_next;
    logic [mmcs_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [mmcs_pkg::DEN_W:0]    trial;
    logic                        fits;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        trial = {rem_reg, quo_reg[mmcs_pkg::QUO_W-1]};
        fits  = (trial >= {1'b0, denom});

        if (ctrl.start)
        begin
            rem_next  = numer[mmcs_pkg::NUM_W-2 -: mmcs_pkg::DEN_W];
            quo_next  = numer[mmcs_pkg::QUO_W-1:0];
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = mmcs_pkg::DEN_W'(trial - {1'b0, denom});
            end
            else
            begin
                rem_next = trial[mmcs_pkg::DEN_W-1:0];
            end
            quo_next  = {quo_reg[mmcs_pkg::QUO_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == mmcs_pkg::STEP_W'(mmcs_pkg::QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== src/min_max_contrast_stretch_unit.sv =====
// Min-max contrast stretch over one frame of up to MAX_SAMPLES samples.
//
// Input stream (s_*): each transfer is one item. s_tuser selects the kind:
// load (0) stores s_tdata and updates the frame minimum and maximum; drain
// (1) returns the next stored sample rescaled so that min maps to 0 and max
// maps to max_value, rounded half up. Loads past capacity are dropped and
// set a sticky overflow flag. A drain with nothing stored gives nothing.
// Output stream (m_*): m_tdata is the scaled sample, m_tlast marks the last
// stored sample of the frame (the frame state then clears itself), m_tuser
// is the overflow flag of that frame.
// The user must write max_value via cfg_we/cfg_data only while idle; not enforced.
//
// Timing: a load is stored at its transfer and keeps s_tready high. After a
// drain transfer s_tready is low through multiply on the read sample, divider
// start, 16 divider steps (one quotient bit each), divider done and output
// load, which raises m_tvalid; no new item is taken before the drain is done.
// One finished result can wait in the output register while loads flow; a
// further drain stalls in its last step until m_tready frees the register.
// Reset: empty frame, max_value 255, min 255, max 0, no overflow, no output.
module min_max_contrast_stretch_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample
    input  logic        s_tuser,    // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] scaled_sample
    output logic        m_tlast,    // last
    output logic        m_tuser,    // [0] overflow

    input  logic        cfg_we,
    input  logic [15:0] cfg_data    // max_value
);

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_START = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // frame state
    mmcs_pkg::sample_t               max_value_reg, max_value_next;
    logic [mmcs_pkg::CNT_W-1:0]      stored_count_reg, stored_count_next;
    logic [mmcs_pkg::CNT_W-1:0]      drain_index_reg, drain_index_next;
    mmcs_pkg::sample_t               running_min_reg, running_min_next;
    mmcs_pkg::sample_t               running_max_reg, running_max_next;
    logic                            dropped_reg, dropped_next;

    // snapshot of one drain in flight
    mmcs_pkg::sample_t               w_min_reg, w_min_next;
    mmcs_pkg::sample_t               w_range_reg, w_range_next;
    logic                            w_flat_reg, w_flat_next;
    logic                            w_last_reg, w_last_next;
    logic                            w_ovf_reg, w_ovf_next;
    logic                            zero_reg, zero_next;
    logic [2*mmcs_pkg::DATA_W-1:0]   prod_reg, prod_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    mmcs_pkg::sample_t               out_data_reg, out_data_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_ovf_reg, out_ovf_next;

    logic                            accept;
    logic                            is_drain;
    logic                            full;
    logic                            has_data;
    logic                            mem_we;
    logic                            mem_re;
    logic                            out_load;
    mmcs_pkg::sample_t               sample_in;
    mmcs_pkg::sample_t               rd_data;
    mmcs_pkg::sample_t               diff;
    logic [mmcs_pkg::CNT_W-1:0]      drain_inc;

    mmcs_pkg::div_ctrl_t             div_ctrl;
    mmcs_pkg::div_stat_t             div_stat;
    logic [mmcs_pkg::NUM_W-1:0]      div_numer;
    logic [mmcs_pkg::DEN_W-1:0]      div_denom;
    logic [mmcs_pkg::QUO_W-1:0]      div_quo;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_drain  = (mmcs_pkg::mode_t'(s_tuser) == mmcs_pkg::MODE_DRAIN);
    assign sample_in = s_tdata & mmcs_pkg::SAMPLE_MASK;
    assign full      = (stored_count_reg >= mmcs_pkg::CAPACITY);
    assign has_data  = (drain_index_reg < stored_count_reg);
    assign drain_inc = drain_index_reg + 1'b1;

    assign mem_we = accept && !is_drain && !full;
    assign mem_re = accept && is_drain && has_data;

    // numerator 2*d*mv + range; quotient never exceeds mv since d <= range
    assign div_numer = {1'b0, prod_reg, 1'b0} + mmcs_pkg::NUM_W'(w_range_reg);
    assign div_denom = {w_range_reg, 1'b0};
    assign div_ctrl.start = (state_reg == ST_START);

    assign diff     = rd_data - w_min_reg;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    mmcs_frame_store u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (stored_count_reg[mmcs_pkg::ADDR_W-1:0]),
        .wdata (sample_in),
        .re    (mem_re),
        .raddr (drain_index_reg[mmcs_pkg::ADDR_W-1:0]),
        .rdata (rd_data)
    );

    mmcs_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .numer    (div_numer),
        .denom    (div_denom),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next        = state_reg;
        max_value_next    = max_value_reg;
        stored_count_next = stored_count_reg;
        drain_index_next  = drain_index_reg;
        running_min_next  = running_min_reg;
        running_max_next  = running_max_reg;
        dropped_next      = dropped_reg;
        w_min_next        = w_min_reg;
        w_range_next      = w_range_reg;
        w_flat_next       = w_flat_reg;
        w_last_next       = w_last_reg;
        w_ovf_next        = w_ovf_reg;
        zero_next         = zero_reg;
        prod_next         = prod_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_data_next     = out_data_reg;
        out_last_next     = out_last_reg;
        out_ovf_next      = out_ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !is_drain)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        stored_count_next = stored_count_reg + 1'b1;
                        if (sample_in < running_min_reg)
                        begin
                            running_min_next = sample_in;
                        end
                        if (sample_in > running_max_reg)
                        begin
                            running_max_next = sample_in;
                        end
                    end
                end
                else if (mem_re)
                begin
                    // snapshot, then advance the frame state right away
                    w_min_next   = running_min_reg;
                    w_range_next = running_max_reg - running_min_reg;
                    w_flat_next  = (running_max_reg <= running_min_reg);
                    w_ovf_next   = dropped_reg;
                    w_last_next  = (drain_inc >= stored_count_reg);
                    drain_index_next = drain_inc;
                    if (drain_inc >= stored_count_reg)
                    begin
                        stored_count_next = '0;
                        drain_index_next  = '0;
                        running_min_next  = max_value_reg;
                        running_max_next  = '0;
                        dropped_next      = 1'b0;
                    end
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                zero_next  = w_flat_reg || (rd_data <= w_min_reg);
                prod_next  = diff * max_value_reg;
                state_next = ST_START;
            end

            ST_START:
            begin
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = zero_reg ? '0 : div_quo;
                    out_last_next  = w_last_reg;
                    out_ovf_next   = w_ovf_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register write; an empty frame also takes the new minimum seed
        if (cfg_we)
        begin
            max_value_next = cfg_data;
            if (stored_count_reg == '0)
            begin
                running_min_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            max_value_reg    <= mmcs_pkg::MAX_VALUE_RST;
            stored_count_reg <= '0;
            drain_index_reg  <= '0;
            running_min_reg  <= mmcs_pkg::MAX_VALUE_RST;
            running_max_reg  <= '0;
            dropped_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            max_value_reg    <= max_value_next;
            stored_count_reg <= stored_count_next;
            drain_index_reg  <= drain_index_next;
            running_min_reg  <= running_min_next;
            running_max_reg  <= running_max_next;
            dropped_reg      <= dropped_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_min_reg    <= w_min_next;
        w_range_reg  <= w_range_next;
        w_flat_reg   <= w_flat_next;
        w_last_reg   <= w_last_next;
        w_ovf_reg    <= w_ovf_next;
        zero_reg     <= zero_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    // divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
    else $error("divider done outside wait state");

    // fill count never passes capacity, drain pointer never passes fill
    assert property (@(posedge clk) disable iff (!rst_n)
        (stored_count_reg <= mmcs_pkg::CAPACITY) && (drain_index_reg <= stored_count_reg))
    else $error("frame counters out of range");

    // flat frames and samples at the minimum come out as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && zero_reg) |=> (m_tvalid && (m_tdata == '0)))
    else $error("zero case not honoured");

    // a drain's work starts only when a stored sample is read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_MUL) |-> mem_re)
    else $error("drain started without a stored sample");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    // Run sizing
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
    localparam int SETTLE_CYCLES  = 40;    // leave room for any drain still in the block to finish
    localparam int RANDOM_ITEMS   = 2000;

    // How the samples of one random frame are spread
    typedef enum int unsigned
    {
        SPREAD_FULL,     // anything in 0..65535
        SPREAD_NARROW,   // within 3 of a base: tiny ranges, lots of rounding halves
        SPREAD_EXTREME,  // 0, full scale or the base
        SPREAD_FLAT      // every sample the same
    } spread_t;

    // One drained sample as it should leave the block
    typedef struct packed
    {
        logic [15:0] scaled;
        logic        last;
        logic        overflow;
    } stretch_pixel_t;

    // Shadow of the frame state plus the queue of pixels still owed by the block.
    class stretch_scoreboard;
        logic [15:0]    full_scale;
        logic [15:0]    frame_mem [mmcs_pkg::MAX_SAMPLES];
        int unsigned    stored;
        int unsigned    drained;
        logic [15:0]    lo;
        logic [15:0]    hi;
        bit             dropped;
        stretch_pixel_t owed_pixels [$];
        int unsigned    errors;
        int unsigned    useful_items;

        function new();
            full_scale   = mmcs_pkg::MAX_VALUE_RST;
            errors       = 0;
            useful_items = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            stored  = 0;
            drained = 0;
            lo      = full_scale;
            hi      = '0;
            dropped = 1'b0;
        endfunction

        // Register write; an empty frame also restarts its minimum from the new value
        function void write_full_scale(logic [15:0] v);
            full_scale = v;
            if (stored == 0)
                lo = v;
        endfunction

        // round((v-lo)*full_scale/(hi-lo)), halves up, done exactly in 64 bits
        function logic [15:0] stretch(logic [15:0] v);
            longint unsigned span;
            longint unsigned num;
            longint unsigned q;
            if (hi <= lo || v <= lo)
                return '0;
            span = 64'(hi) - 64'(lo);
            num  = 64'd2 * (64'(v) - 64'(lo)) * 64'(full_scale) + span;
            q    = num / (64'd2 * span);
            if (q > 64'hFFFF)
                q = 64'hFFFF;
            return q[15:0];
        endfunction

        // Called on every accepted input transfer
        function void note_item(mmcs_pkg::mode_t mode, logic [15:0] sample);
            stretch_pixel_t px;
            logic [15:0]    v;
            if (mode == mmcs_pkg::MODE_LOAD)
            begin
                useful_items++;
                v = sample & mmcs_pkg::SAMPLE_MASK;
                if (stored >= mmcs_pkg::MAX_SAMPLES)
                begin
                    dropped = 1'b1;
                    return;
                end
                frame_mem[stored] = v;
                stored++;
                if (v < lo)
                    lo = v;
                if (v > hi)
                    hi = v;
                return;
            end
            // drain with nothing left: block ignores it
            if (drained >= stored)
                return;
            useful_items++;
            v = frame_mem[drained];
            drained++;
            px.scaled   = stretch(v);
            px.last     = (drained >= stored);
            px.overflow = dropped;
            owed_pixels = {owed_pixels, px};
            if (px.last)
                clear_frame();
        endfunction

        // Called on every accepted output transfer
        function void check_pixel(logic [15:0] scaled, logic last, logic overflow);
            stretch_pixel_t want;
            if (owed_pixels.size() == 0)
            begin
                $display("%0t: output transfer with nothing owed: scaled %0d last %0b ovf %0b",
                         $time, scaled, last, overflow);
                errors++;
                return;
            end
            want = owed_pixels.pop_front();
            if (scaled !== want.scaled)
            begin
                $display("%0t: scaled_sample expected %0d, actual %0d",
                         $time, want.scaled, scaled);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last expected %0b, actual %0b", $time, want.last, last);
                errors++;
            end
            if (overflow !== want.overflow)
            begin
                $display("%0t: overflow expected %0b, actual %0b",
                         $time, want.overflow, overflow);
                errors++;
            end
        endfunction

        function int unsigned open_samples();
            return stored - drained;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;

    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [15:0] sample
    logic        s_tuser;     // [0] mode

    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // [15:0] scaled_sample
    logic        m_tlast;     // last
    logic        m_tuser;     // [0] overflow

    logic        cfg_we;
    logic [15:0] cfg_data;    // max_value

    stretch_scoreboard sb;

    // Idle-free stretches on each side, flipped now and then
    bit          tx_calm;
    bit          rx_calm;
    int unsigned quiet_cycles;

    min_max_contrast_stretch_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Monitor: everything is sampled at the rising edge. Outputs are checked
    // before the input transfer of the same edge is noted; a drain accepted
    // now cannot produce its result at this edge anyway.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_pixel(m_tdata, m_tlast, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_item(mmcs_pkg::mode_t'(s_tuser), s_tdata);
            if (cfg_we)
                sb.write_full_scale(cfg_data);

            // Watchdog: any transfer on either stream or a register write resets it
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, drawn afresh before every transfer.
    // m_tready may drop while a drain is in the divider or while a result
    // already sits in the output register.
    initial
    begin : result_sink
        int unsigned gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = rx_calm ? 0 : $urandom_range(0, 11);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
        end
    end

    // Offer one item and hold it until the transfer. Entered and left at a
    // falling edge; tvalid is left high so a back-to-back item needs no toggle.
    task automatic push_item(input mmcs_pkg::mode_t mode, input logic [15:0] sample);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= sample;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
    endtask

    // Stop offering, wait for every owed pixel, then let any trailing work finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.owed_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One-cycle register write; only ever called with the block idle
    task automatic set_full_scale(input logic [15:0] v);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [15:0] frame_sample(spread_t spread, logic [15:0] base);
        case (spread)
            SPREAD_FULL:
                return 16'($urandom_range(0, 65535));
            SPREAD_NARROW:
                return (base > 16'd65531) ? base - 16'($urandom_range(0, 3))
                                          : base + 16'($urandom_range(0, 3));
            SPREAD_EXTREME:
                case ($urandom_range(0, 2))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    default: return base;
                endcase
            default:
                return base;
        endcase
    endfunction

    // One well-formed frame with random content: n loads then n drains, or
    // loads and drains mixed (never more drains than loads so far). A little
    // noise - stray loads and drains - is sprinkled in; the shadow copes.
    task automatic run_frame();
        int unsigned n;
        int unsigned loads;
        int unsigned drains;
        int unsigned pick;
        spread_t     spread;
        logic [15:0] base;
        bit          mixed;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            n = $urandom_range(1, 12);
        else if (pick < 19)
            n = $urandom_range(13, 64);
        else
            n = $urandom_range(65, 200);
        spread = spread_t'($urandom_range(0, 3));
        base   = 16'($urandom_range(0, 65535));
        mixed  = ($urandom_range(0, 3) == 0);
        loads  = 0;
        drains = 0;
        while (loads < n || drains < n)
        begin
            if ($urandom_range(0, 24) == 0)
                push_item(mmcs_pkg::mode_t'($urandom_range(0, 1)),
                          16'($urandom_range(0, 65535)));
            else if (loads < n && (!mixed || drains >= loads || $urandom_range(0, 1) == 0))
            begin
                push_item(mmcs_pkg::MODE_LOAD, frame_sample(spread, base));
                loads++;
            end
            else
            begin
                push_item(mmcs_pkg::MODE_DRAIN, 16'($urandom_range(0, 65535)));
                drains++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [15:0] scales [6];
        int unsigned phase;
        int unsigned phase_end;
        int unsigned goal;

        scales = '{16'd65535, 16'd1, 16'd0, 16'd4095, 16'd255, 16'd1000};

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = mmcs_pkg::MODE_LOAD;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        quiet_cycles = 0;
        sb           = new();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset full scale of 255.
        // drain with an empty frame: nothing comes back
        push_item(mmcs_pkg::MODE_DRAIN, 16'hFFFF);
        // field extremes and alternating bit patterns
        push_item(mmcs_pkg::MODE_LOAD, 16'h0000);
        push_item(mmcs_pkg::MODE_LOAD, 16'hFFFF);
        push_item(mmcs_pkg::MODE_LOAD, 16'h5555);
        push_item(mmcs_pkg::MODE_LOAD, 16'hAAAA);
        push_item(mmcs_pkg::MODE_LOAD, 16'h0001);
        repeat (5) push_item(mmcs_pkg::MODE_DRAIN, 16'h0000);
        // range of 2: the middle sample lands on a half and rounds up
        push_item(mmcs_pkg::MODE_LOAD, 16'd0);
        push_item(mmcs_pkg::MODE_LOAD, 16'd2);
        push_item(mmcs_pkg::MODE_LOAD, 16'd1);
        repeat (3) push_item(mmcs_pkg::MODE_DRAIN, 16'h0000);
        // flat frame: all zeros out
        push_item(mmcs_pkg::MODE_LOAD, 16'd7);
        push_item(mmcs_pkg::MODE_LOAD, 16'd7);
        repeat (2) push_item(mmcs_pkg::MODE_DRAIN, 16'h0000);
        // load while draining: appended, widens the range for what is left
        push_item(mmcs_pkg::MODE_LOAD, 16'd10);
        push_item(mmcs_pkg::MODE_LOAD, 16'd20);
        push_item(mmcs_pkg::MODE_DRAIN, 16'h0000);
        push_item(mmcs_pkg::MODE_LOAD, 16'd30);
        repeat (2) push_item(mmcs_pkg::MODE_DRAIN, 16'h0000);

        // Random part, phase by phase with a new full scale each time. A
        // phase may end with a few samples left stored, so the next write
        // lands on a non-empty frame.
        goal  = sb.useful_items + RANDOM_ITEMS;
        phase = 0;
        while (phase < 6 || sb.useful_items < goal)
        begin
            wait_idle();
            if (phase < 6)
                set_full_scale(scales[phase]);
            else
                set_full_scale(16'($urandom_range(1, 65535)));
            phase_end = sb.useful_items + $urandom_range(150, 300);
            while (sb.useful_items < phase_end)
                run_frame();
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 4))
                    push_item(mmcs_pkg::MODE_LOAD, 16'($urandom_range(0, 65535)));
            phase++;
        end

        // Drain whatever is still stored so the last frame closes
        while (sb.open_samples() != 0)
            push_item(mmcs_pkg::MODE_DRAIN, 16'($urandom_range(0, 65535)));

        wait_idle();
        if (sb.errors == 0 && sb.owed_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
src/mmcs_pkg.sv
src/mmcs_frame_store.sv
src/mmcs_divider.sv
src/min_max_contrast_stretch_unit.sv
test/tb_top.sv
